// ===== rtl/core/serial_command_light_selector_macros.svh =====
// assertion macros for the serial command light selector
`ifndef SERIAL_COMMAND_LIGHT_SELECTOR_MACROS_SVH
`define SERIAL_COMMAND_LIGHT_SELECTOR_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, disabled during reset
`define SCLSEL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("sclsel check failed");
// next-cycle implication, disabled during reset
`define SCLSEL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("sclsel check failed");
`else
`define SCLSEL_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SCLSEL_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/sclsel_pkg.sv =====
// shared types, codes and decode function for the serial command light selector
`default_nettype none

package sclsel_pkg;

	// prefix bytes that wait for an argument
	localparam logic [7:0] PFX_BOTH    = 8'hFF;
	localparam logic [7:0] PFX_SPEAKER = 8'hFE;
	localparam logic [7:0] PFX_LIGHT   = 8'hFD;
	localparam logic [7:0] PFX_POT     = 8'hFA;
	localparam logic [7:0] PFX_DIRECT  = 8'hFC;

	// pending prefix codes
	localparam logic [2:0] PEND_BOTH    = 3'd0;
	localparam logic [2:0] PEND_SPEAKER = 3'd1;
	localparam logic [2:0] PEND_LIGHT   = 3'd2;
	localparam logic [2:0] PEND_POT     = 3'd3;
	localparam logic [2:0] PEND_DIRECT  = 3'd4;

	localparam logic [7:0] LOW_NIBBLE = 8'h0F;

	// one result beat
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       pot_write;
		logic [9:0] pot_word;
		logic [4:0] light_lines;
		logic [4:0] speaker_lines;
		logic       last;
	} result_t;

	// select 1..5 gives one-hot lines, anything else all low
	function automatic logic [4:0] decode_one_hot(input logic [7:0] sel);
		logic [4:0] lines;
		case (sel)
			8'd1: lines = 5'b00001;
			8'd2: lines = 5'b00010;
			8'd3: lines = 5'b00100;
			8'd4: lines = 5'b01000;
			8'd5: lines = 5'b10000;
			default: lines = 5'b00000;
		endcase
		return lines;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sclsel_cmd.sv =====
// command interpreter: prefix tracking, select registers and line state
`default_nettype none

module sclsel_cmd (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [7:0]        rx_byte,
	output logic [1:0]             res_count,
	output sclsel_pkg::result_t    res0,
	output sclsel_pkg::result_t    res1
);
	import sclsel_pkg::*;

	logic       awaiting_q;
	logic [2:0] pending_q;
	logic [7:0] light_sel_q;
	logic [7:0] speaker_sel_q;
	logic [4:0] light_state_q;
	logic [4:0] speaker_state_q;

	logic       is_prefix;
	logic [2:0] code;
	logic [7:0] echo;
	logic       pot;
	logic [7:0] light_sel_n;
	logic [7:0] speaker_sel_n;
	logic [4:0] light_state_n;
	logic [4:0] speaker_state_n;

	// prefix recognition while no argument is due
	always_comb begin
		is_prefix = 1'b0;
		code = PEND_BOTH;
		if (!awaiting_q) begin
			case (rx_byte)
				PFX_BOTH: begin
					is_prefix = 1'b1;
					code = PEND_BOTH;
				end
				PFX_SPEAKER: begin
					is_prefix = 1'b1;
					code = PEND_SPEAKER;
				end
				PFX_LIGHT: begin
					is_prefix = 1'b1;
					code = PEND_LIGHT;
				end
				PFX_POT: begin
					is_prefix = 1'b1;
					code = PEND_POT;
				end
				PFX_DIRECT: begin
					is_prefix = 1'b1;
					code = PEND_DIRECT;
				end
				default: begin
					is_prefix = 1'b0;
				end
			endcase
		end
	end

	// argument handling and select updates
	always_comb begin
		echo = rx_byte;
		pot = 1'b0;
		light_sel_n = light_sel_q;
		speaker_sel_n = speaker_sel_q;
		light_state_n = light_state_q;
		speaker_state_n = speaker_state_q;
		if (awaiting_q) begin
			case (pending_q)
				PEND_BOTH: begin
					light_sel_n = rx_byte & LOW_NIBBLE;
					speaker_sel_n = {4'd0, rx_byte[7:4]};
					echo = PFX_BOTH;
				end
				PEND_SPEAKER: begin
					speaker_sel_n = rx_byte;
					echo = PFX_SPEAKER;
				end
				PEND_LIGHT: begin
					light_sel_n = rx_byte;
					echo = PFX_LIGHT;
				end
				PEND_POT: begin
					echo = PFX_POT;
					pot = 1'b1;
				end
				PEND_DIRECT: begin
					light_state_n = rx_byte[4:0];
					echo = PFX_DIRECT;
				end
				default: begin
					echo = rx_byte;
				end
			endcase
		end
		// re-decode only a select that changed
		if (light_sel_n != light_sel_q) begin
			light_state_n = decode_one_hot(light_sel_n);
		end
		if (speaker_sel_n != speaker_sel_q) begin
			speaker_state_n = decode_one_hot(speaker_sel_n);
		end
	end

	// result beats for this byte
	always_comb begin
		if (is_prefix) begin
			res_count = 2'd0;
		end else if (pot) begin
			res_count = 2'd2;
		end else begin
			res_count = 2'd1;
		end
		res0.tx_byte = echo;
		res0.pot_write = 1'b0;
		res0.pot_word = 10'd0;
		res0.light_lines = light_state_n;
		res0.speaker_lines = speaker_state_n;
		res0.last = !pot;
		res1.tx_byte = rx_byte;
		res1.pot_write = 1'b1;
		res1.pot_word = {2'b00, rx_byte};
		res1.light_lines = light_state_n;
		res1.speaker_lines = speaker_state_n;
		res1.last = 1'b1;
	end

	// state update on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			pending_q <= PEND_BOTH;
			light_sel_q <= 8'd0;
			speaker_sel_q <= 8'd0;
			light_state_q <= 5'd0;
			speaker_state_q <= 5'd0;
		end else if (fire) begin
			awaiting_q <= is_prefix;
			pending_q <= is_prefix ? code : PEND_BOTH;
			light_sel_q <= light_sel_n;
			speaker_sel_q <= speaker_sel_n;
			light_state_q <= light_state_n;
			speaker_state_q <= speaker_state_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/sclsel_outq.sv =====
// two-entry result queue that takes up to two beats per cycle
`default_nettype none

module sclsel_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_req,
	input  wire logic [1:0]        push_n,
	input  wire sclsel_pkg::result_t push0,
	input  wire sclsel_pkg::result_t push1,
	output logic                   push_ok,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output sclsel_pkg::result_t    head
);
	import sclsel_pkg::*;

	result_t    ent_q [2];
	logic [1:0] count_q;

	result_t    ent_n [2];
	logic [1:0] count_base;
	logic [1:0] room;
	logic       pop;
	logic       push;

	assign out_valid = (count_q != 2'd0);
	assign head = ent_q[0];
	assign pop = out_valid && !out_stall;
	// free slots after this cycle's pop
	assign room = (2'd2 - count_q) + {1'b0, pop};
	assign push_ok = (push_n <= room);
	assign push = push_req && push_ok;

	// shift on pop, then append at the tail
	always_comb begin
		ent_n[0] = ent_q[0];
		ent_n[1] = ent_q[1];
		count_base = count_q;
		if (pop) begin
			ent_n[0] = ent_q[1];
			count_base = count_q - 2'd1;
		end
		if (push && (push_n != 2'd0)) begin
			if (count_base == 2'd0) begin
				ent_n[0] = push0;
				ent_n[1] = push1;
			end else begin
				ent_n[1] = push0;
			end
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		ent_q[0] <= ent_n[0];
		ent_q[1] <= ent_n[1];
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_base + (push ? push_n : 2'd0);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/serial_command_light_selector.sv =====
// top level of the serial command light selector
// Usage:
//   Input channel: rx_byte with in_valid / in_stall, one received link byte a beat.
//   Output channel: tx_byte, pot_write, pot_word, light_lines, speaker_lines, last
//   with out_valid / out_stall. A prefix byte (FF, FE, FD, FA, FC) gives no beat;
//   its argument gives one beat echoing the prefix, or two beats after FA (echo of
//   FA, then the argument with pot_write set). Any other byte is echoed at once.
//   last marks the final beat of each byte.
// Timing:
//   An accepted byte is registered in the input register, interpreted from there
//   by the command interpreter and written into a two-entry result queue once the
//   queue has room for its beats; its first beat is then valid at the queue head.
//   One byte can be taken every cycle while the receiver takes every beat; the
//   two beats of an FA argument fit because the FA prefix before it gives none.
// Reset: arst_n clears the prefix tracker, the selects, the line state and the
//   queue count; the queue entries, and so the line outputs, are not reset.
// Stall: while out_stall is high the queue holds; once it cannot take the
//   registered byte's beats, in_stall rises and the input register holds.
`default_nettype none

`include "serial_command_light_selector_macros.svh"

module serial_command_light_selector (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      tx_byte,
	output logic            pot_write,
	output logic [9:0]      pot_word,
	output logic [4:0]      light_lines,
	output logic [4:0]      speaker_lines,
	output logic            last
);
	import sclsel_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       push_ok;
	logic       fire;
	logic [1:0] res_count;
	result_t    res0;
	result_t    res1;
	result_t    head;
	logic       pot_beat_ok;

	assign in_stall = valid_s1 && !push_ok;
	assign fire = valid_s1 && push_ok;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// command interpreter
	sclsel_cmd u_cmd (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.rx_byte   (byte_s1),
		.res_count (res_count),
		.res0      (res0),
		.res1      (res1)
	);

	// result queue
	sclsel_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_req  (valid_s1),
		.push_n    (res_count),
		.push0     (res0),
		.push1     (res1),
		.push_ok   (push_ok),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	// output beat fields
	assign tx_byte = head.tx_byte;
	assign pot_write = head.pot_write;
	assign pot_word = head.pot_word;
	assign light_lines = head.light_lines;
	assign speaker_lines = head.speaker_lines;
	assign last = head.last;

	// pot beat is final and carries the echoed byte on channel zero
	assign pot_beat_ok = last && (pot_word[7:0] == tx_byte) && (pot_word[9:8] == 2'b00);

	// checks
	`SCLSEL_ASSERT_IMP(a_stall_needs_byte, clk, arst_n, in_stall, valid_s1)
	`SCLSEL_ASSERT_IMP(a_pot_beat_shape, clk, arst_n, out_valid && pot_write, pot_beat_ok)
	`SCLSEL_ASSERT_IMP(a_speaker_onehot, clk, arst_n, out_valid, $onehot0(speaker_lines))
	`SCLSEL_ASSERT_NXT(a_second_beat_follows, clk, arst_n, out_valid && !last && !out_stall, out_valid && pot_write)

endmodule

`default_nettype wire

// ===== test/serial_command_light_selector_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the serial command light selector: link byte stream in, echo beats checked
module serial_command_light_selector_tb;
	import sclsel_pkg::*;

	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 20;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// input channel
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte  = 8'h00;

	// output channel
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] tx_byte;
	logic       pot_write;
	logic [9:0] pot_word;
	logic [4:0] light_lines;
	logic [4:0] speaker_lines;
	logic       last;

	// stimulus and expected beats
	logic [7:0] link_bytes[$];
	result_t    echo_beats_due[$];

	// idling controls
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int holds_asked        = 0;
	int holds_done         = 0;
	int hold_left          = 0;

	int mismatch_count = 0;
	int stuck_cycles   = 0;

	// predicted block state
	logic       arg_due          = 1'b0;
	logic [2:0] held_prefix      = PEND_BOTH;
	logic [7:0] light_sel        = 8'h00;
	logic [7:0] speaker_sel      = 8'h00;
	logic [7:0] light_sel_seen   = 8'h00;
	logic [7:0] speaker_sel_seen = 8'h00;
	logic [4:0] light_now        = 5'b00000;
	logic [4:0] speaker_now      = 5'b00000;

	// extremes, every prefix, argument equal to a prefix, direct write then same select
	logic [7:0] directed_bytes [25] = '{
		8'h00, 8'h7F, 8'hFB,
		PFX_BOTH, 8'h31,
		PFX_SPEAKER, 8'h05,
		PFX_LIGHT, 8'h04,
		PFX_POT, 8'h00,
		PFX_POT, 8'hFF,
		PFX_DIRECT, 8'h1F,
		PFX_LIGHT, 8'h04,
		PFX_BOTH, 8'hF6,
		PFX_SPEAKER, PFX_SPEAKER,
		PFX_DIRECT, 8'hE0,
		PFX_LIGHT, PFX_LIGHT
	};

	serial_command_light_selector dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.tx_byte      (tx_byte),
		.pot_write    (pot_write),
		.pot_word     (pot_word),
		.light_lines  (light_lines),
		.speaker_lines(speaker_lines),
		.last         (last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// select 1..5 lights one line, anything else none
	function automatic logic [4:0] one_hot_lines(input logic [7:0] sel);
		if (sel >= 8'd1 && sel <= 8'd5)
			return 5'b00001 << (sel - 8'd1);
		return 5'b00000;
	endfunction

	// advance the predicted state by one link byte and queue the beats it causes
	task automatic predict_link_byte(input logic [7:0] b);
		logic [7:0] echo;
		logic       pot;
		echo = b;
		pot  = 1'b0;
		if (!arg_due) begin
			case (b)
				PFX_BOTH: begin
					held_prefix = PEND_BOTH;
					arg_due = 1'b1;
				end
				PFX_SPEAKER: begin
					held_prefix = PEND_SPEAKER;
					arg_due = 1'b1;
				end
				PFX_LIGHT: begin
					held_prefix = PEND_LIGHT;
					arg_due = 1'b1;
				end
				PFX_POT: begin
					held_prefix = PEND_POT;
					arg_due = 1'b1;
				end
				PFX_DIRECT: begin
					held_prefix = PEND_DIRECT;
					arg_due = 1'b1;
				end
				default: ;
			endcase
			// prefix alone sends nothing
			if (arg_due)
				return;
		end else begin
			arg_due = 1'b0;
			case (held_prefix)
				PEND_BOTH: begin
					light_sel   = b & LOW_NIBBLE;
					speaker_sel = b >> 4;
					echo = PFX_BOTH;
				end
				PEND_SPEAKER: begin
					speaker_sel = b;
					echo = PFX_SPEAKER;
				end
				PEND_LIGHT: begin
					light_sel = b;
					echo = PFX_LIGHT;
				end
				PEND_POT: begin
					echo = PFX_POT;
					pot  = 1'b1;
				end
				PEND_DIRECT: begin
					light_now = b[4:0];
					echo = PFX_DIRECT;
				end
				default: ;
			endcase
			held_prefix = PEND_BOTH;
		end
		// re-decode only selects that moved
		if (light_sel != light_sel_seen) begin
			light_sel_seen = light_sel;
			light_now = one_hot_lines(light_sel);
		end
		if (speaker_sel != speaker_sel_seen) begin
			speaker_sel_seen = speaker_sel;
			speaker_now = one_hot_lines(speaker_sel);
		end
		echo_beats_due.push_back('{tx_byte: echo, pot_write: 1'b0, pot_word: 10'd0,
			light_lines: light_now, speaker_lines: speaker_now, last: !pot});
		if (pot)
			echo_beats_due.push_back('{tx_byte: b, pot_write: 1'b1, pot_word: {2'b00, b},
				light_lines: light_now, speaker_lines: speaker_now, last: 1'b1});
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// mostly prefix plus argument pairs, the rest loose bytes
	task automatic queue_random_bytes(input int count);
		int         left;
		logic [7:0] pfx;
		logic [7:0] arg;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 9) < 6) begin
				case ($urandom_range(0, 4))
					0: pfx = PFX_BOTH;
					1: pfx = PFX_SPEAKER;
					2: pfx = PFX_LIGHT;
					3: pfx = PFX_POT;
					default: pfx = PFX_DIRECT;
				endcase
				if ($urandom_range(0, 1) != 0)
					arg = 8'($urandom_range(0, 6));
				else
					arg = 8'($urandom_range(0, 255));
				link_bytes.push_back(pfx);
				link_bytes.push_back(arg);
				left -= 2;
			end else begin
				link_bytes.push_back(8'($urandom_range(0, 255)));
				left--;
			end
		end
	endtask

	// wait until every byte is taken and every beat has come back
	task automatic wait_drained();
		while (link_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (echo_beats_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic start_phase(input int sender_pct, input int receiver_pct);
		@(negedge clk);
		sender_idle_pct    = sender_pct;
		receiver_stall_pct = receiver_pct;
	endtask

	// sender: offers queued bytes, holds a beat until taken, predicts on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'h00;
		end else begin
			if (in_valid && !in_stall)
				predict_link_byte(rx_byte);
			if (!in_valid || !in_stall) begin
				if (link_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte  <= link_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall, or a long hold when one is asked for
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_done != holds_asked) begin
			out_stall  <= 1'b1;
			hold_left  <= HOLD_CYCLES - 1;
			holds_done <= holds_done + 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
		end
	end

	// compare each taken beat with the oldest expected one
	always @(posedge clk) begin : beat_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (echo_beats_due.size() == 0) begin
				report_mismatch($sformatf("beat with nothing expected, tx_byte %0h", tx_byte));
			end else begin
				want = echo_beats_due.pop_front();
				check_field("tx_byte", tx_byte, want.tx_byte);
				check_field("pot_write", pot_write, want.pot_write);
				check_field("pot_word", pot_word, want.pot_word);
				check_field("light_lines", light_lines, want.light_lines);
				check_field("speaker_lines", speaker_lines, want.speaker_lines);
				check_field("last", last, want.last);
			end
		end
	end

	// watchdog on cycles without any beat moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles == WATCHDOG_LIMIT) begin
				$display("[serial_command_light_selector] ERROR");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	// reset, then the stimulus phases
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed bytes, no idling
		start_phase(0, 0);
		foreach (directed_bytes[i])
			link_bytes.push_back(directed_bytes[i]);
		wait_drained();

		start_phase(0, 0);
		queue_random_bytes(250);
		wait_drained();

		start_phase(86, 0);
		queue_random_bytes(200);
		wait_drained();

		start_phase(0, 86);
		queue_random_bytes(200);
		wait_drained();

		start_phase(17, 17);
		queue_random_bytes(200);
		wait_drained();

		// long receiver hold while the sender keeps offering echo bytes
		start_phase(0, 0);
		holds_asked = holds_asked + 1;
		repeat (60)
			link_bytes.push_back(8'($urandom_range(0, 8'hF9)));
		wait_drained();

		start_phase(0, 0);
		queue_random_bytes(40);
		wait_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && echo_beats_due.size() == 0)
			$display("[serial_command_light_selector] OK");
		else
			$display("[serial_command_light_selector] ERROR");
		$finish;
	end

endmodule

// ===== serial_command_light_selector.f =====
+incdir+rtl/core
rtl/core/sclsel_pkg.sv
rtl/core/sclsel_cmd.sv
rtl/core/sclsel_outq.sv
rtl/core/serial_command_light_selector.sv
test/serial_command_light_selector_tb.sv
